[hw/rtl/mac_learning_switch_forwarder_core_assert.svh]
// assertion macros used by the checker file
`ifndef MAC_LEARNING_SWITCH_FORWARDER_CORE_ASSERT_SVH
`define MAC_LEARNING_SWITCH_FORWARDER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MLSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define MLSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/mlsf_pkg.sv]
`default_nettype none

package mlsf_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int NUM_PORTS       = 8;
  localparam int MAC_W           = 48;
  localparam int PORT_W          = 3;
  localparam int CFG_W           = 4;
  localparam int QUEUE_DEPTH     = 2;

  // ports that can be active: limited by the switch and by out_port width
  localparam int PORT_CAP = (NUM_PORTS < (1 << PORT_W)) ? NUM_PORTS : (1 << PORT_W);

  typedef logic [MAC_W-1:0]  mac_t;
  typedef logic [PORT_W-1:0] port_t;
  typedef logic [CFG_W-1:0]  count_t;

  localparam count_t PORTS_RESET = CFG_W'(8);
  localparam mac_t   BCAST_MAC   = '1;

  // forwarding request handed from the learn stage to the emit stage
  typedef struct packed {
    logic   flood;
    port_t  port;
    port_t  in_port;
    count_t nports;
  } fwd_cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_DECIDE,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_FLOOD
  } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/mlsf_front.sv]
`default_nettype none

module mlsf_front #(
  parameter int TABLE_DEPTH = mlsf_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mlsf_pkg::mac_t    src_mac,
  input  mlsf_pkg::mac_t    dst_mac,
  input  mlsf_pkg::port_t   in_port,
  input  mlsf_pkg::count_t  ports_in_use,
  input  logic              q_full,
  output logic              q_push,
  output mlsf_pkg::fwd_cmd_t q_cmd
);
  import mlsf_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FILL_MAX  = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam count_t        CAP       = CFG_W'(PORT_CAP);

  typedef logic [MAC_W+PORT_W-1:0] entry_t;

  front_state_t state, state_next;

  // address table: mac in the upper bits, learned port in the lower bits
  entry_t entry_mem [TABLE_DEPTH];

  mac_t    src_q, dst_q;
  port_t   inport_q;
  count_t  nports_q;
  logic [CW-1:0] fill;
  logic [AW-1:0] wptr;
  logic [CW-1:0] issue_cnt;
  logic          rd_valid, rd_last;
  logic [AW-1:0] rd_idx;
  entry_t        rd_data;
  logic          src_hit, dst_hit;
  logic [AW-1:0] src_idx, dst_idx, wr_addr;
  port_t         dst_port;
  fwd_cmd_t      cmd;

  count_t n_eff;
  logic   accept, drop, rd_en, scan_done, src_match, dst_match;
  logic   is_bcast, same_mac, dst_found;

  // effective port count and request classification
  assign n_eff     = (ports_in_use > CAP) ? CAP : ports_in_use;
  assign accept    = start && (state == F_IDLE);
  assign drop      = count_t'(in_port) >= n_eff;
  assign busy      = (state != F_IDLE);

  // table scan, one entry per cycle through the read port
  assign rd_en     = (state == F_SCAN) && (issue_cnt < fill);
  assign scan_done = rd_valid && rd_last;
  assign src_match = rd_valid && (rd_data[MAC_W+PORT_W-1:PORT_W] == src_q);
  assign dst_match = rd_valid && (rd_data[MAC_W+PORT_W-1:PORT_W] == dst_q);

  // destination decision; an entry evicted by this learn no longer counts
  assign is_bcast  = (dst_q == BCAST_MAC);
  assign same_mac  = (dst_q == src_q);
  assign dst_found = !is_bcast &&
                     (same_mac || (dst_hit && (src_hit || (dst_idx != wptr))));
  assign wr_addr   = src_hit ? src_idx : wptr;

  assign q_push = (state == F_PUSH) && !q_full;
  assign q_cmd  = cmd;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept && !drop) begin
          state_next = (fill == '0) ? F_DECIDE : F_SCAN;
        end
      end
      F_SCAN: begin
        if (scan_done) begin
          state_next = F_DECIDE;
        end
      end
      F_DECIDE: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      fill     <= '0;
      wptr     <= '0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      rd_last  <= rd_en && (issue_cnt == (fill - CW'(1)));
      if ((state == F_DECIDE) && !src_hit) begin
        wptr <= (wptr == LAST_SLOT) ? '0 : wptr + AW'(1);
        if (fill != FILL_MAX) begin
          fill <= fill + CW'(1);
        end
      end
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (state == F_DECIDE) begin
      entry_mem[wr_addr] <= {src_q, inport_q};
    end
    if (rd_en) begin
      rd_data <= entry_mem[issue_cnt[AW-1:0]];
    end
  end

  // request capture, scan results and the forwarding request
  always_ff @(posedge clk) begin
    if (accept) begin
      src_q     <= src_mac;
      dst_q     <= dst_mac;
      inport_q  <= in_port;
      nports_q  <= n_eff;
      issue_cnt <= '0;
      src_hit   <= 1'b0;
      dst_hit   <= 1'b0;
    end else begin
      if (rd_en) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (src_match) begin
        src_hit <= 1'b1;
        src_idx <= rd_idx;
      end
      if (dst_match) begin
        dst_hit  <= 1'b1;
        dst_idx  <= rd_idx;
        dst_port <= rd_data[PORT_W-1:0];
      end
    end
    rd_idx <= issue_cnt[AW-1:0];
    if (state == F_DECIDE) begin
      cmd.flood   <= !dst_found;
      cmd.port    <= same_mac ? inport_q : dst_port;
      cmd.in_port <= inport_q;
      cmd.nports  <= nports_q;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mlsf_fifo.sv]
`default_nettype none

module mlsf_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mlsf_pkg::fwd_cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output mlsf_pkg::fwd_cmd_t pop_cmd,
  output logic               empty
);
  import mlsf_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
  localparam logic [NW-1:0] COUNT_MAX = NW'(QUEUE_DEPTH);

  fwd_cmd_t      slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign full    = (count == COUNT_MAX);
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + QW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mlsf_back.sv]
`default_nettype none

module mlsf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  mlsf_pkg::fwd_cmd_t q_cmd,
  output logic               out_valid,
  output mlsf_pkg::port_t    out_port,
  output logic               flooded,
  output logic               last
);
  import mlsf_pkg::*;

  back_state_t state, state_next;

  port_t p, top, skip;
  port_t n_minus1, top_calc, p_first, p_inc, p_step;
  logic  none, emit_hit, start_flood;

  // flood range for the request at the head of the queue
  assign n_minus1 = PORT_W'(q_cmd.nports - CFG_W'(1));
  assign top_calc = (n_minus1 == q_cmd.in_port) ? n_minus1 - PORT_W'(1) : n_minus1;
  assign p_first  = (q_cmd.in_port == '0) ? PORT_W'(1) : '0;
  assign none     = (q_cmd.nports == CFG_W'(1));

  assign q_pop       = (state == B_IDLE) && !q_empty;
  assign emit_hit    = q_pop && !q_cmd.flood;
  assign start_flood = q_pop && q_cmd.flood && !none;

  // next flood port, stepping over the ingress port
  assign p_inc  = p + PORT_W'(1);
  assign p_step = (p_inc == skip) ? p + PORT_W'(2) : p_inc;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (start_flood) begin
          state_next = B_FLOOD;
        end
      end
      B_FLOOD: begin
        if (p == top) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= emit_hit || (state == B_FLOOD);
    end
  end

  // flood walker and result registers
  always_ff @(posedge clk) begin
    if (start_flood) begin
      p    <= p_first;
      top  <= top_calc;
      skip <= q_cmd.in_port;
    end else if (state == B_FLOOD) begin
      p <= p_step;
    end
    if (emit_hit) begin
      out_port <= q_cmd.port;
      flooded  <= 1'b0;
      last     <= 1'b1;
    end else begin
      out_port <= p;
      flooded  <= 1'b1;
      last     <= (p == top);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mac_learning_switch_forwarder_core.sv]
`default_nettype none

// MAC learning bridge. A request (start high while busy is low) carries a
// frame's source MAC, destination MAC and ingress port. The learn stage scans
// the address table one entry per cycle through its single read port, so busy
// stays high through the scan of the N entries learned so far (at most
// TABLE_DEPTH, none if the table is empty), then decide and push; it also holds
// while the two-entry request queue is full. A frame whose ingress port is not
// below the active port count is dropped at once and busy never rises. The
// emit stage sends one result per cycle on out_valid: one result for a table
// hit, or one per active port other than the ingress port for a flood, with
// last on the final one; a frame's results come in consecutive cycles. There
// is no backpressure on results: the receiver must take each one in the cycle
// it appears. ports_in_use is written by cfg_wr_en and must only change while
// the block is idle.
module mac_learning_switch_forwarder_core #(
  parameter int TABLE_DEPTH = mlsf_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mlsf_pkg::mac_t   src_mac,
  input  mlsf_pkg::mac_t   dst_mac,
  input  mlsf_pkg::port_t  in_port,
  input  logic             cfg_wr_en,
  input  mlsf_pkg::count_t cfg_wr_data,
  output logic             out_valid,
  output mlsf_pkg::port_t  out_port,
  output logic             flooded,
  output logic             last
);
  import mlsf_pkg::*;

  count_t   ports_in_use;
  fwd_cmd_t push_cmd, pop_cmd;
  logic     q_push, q_full, q_pop, q_empty;

  // port count register
  always_ff @(posedge clk) begin
    if (rst) begin
      ports_in_use <= PORTS_RESET;
    end else if (cfg_wr_en) begin
      ports_in_use <= cfg_wr_data;
    end
  end

  mlsf_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .src_mac      (src_mac),
    .dst_mac      (dst_mac),
    .in_port      (in_port),
    .ports_in_use (ports_in_use),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  mlsf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  mlsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .out_valid (out_valid),
    .out_port  (out_port),
    .flooded   (flooded),
    .last      (last)
  );

endmodule

`default_nettype wire

[hw/rtl/mlsf_checker.sv]
`default_nettype none

`include "mac_learning_switch_forwarder_core_assert.svh"

module mlsf_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            out_valid,
  input wire mlsf_pkg::port_t out_port,
  input wire logic            flooded,
  input wire logic            last
);

  logic flood_cont;

  // a frame's results come back to back until last
  `MLSF_ASSERT_NEXT(a_results_contiguous, out_valid && !last, out_valid)

  // a table hit gives exactly one result
  `MLSF_ASSERT_SAME(a_hit_single, out_valid && !flooded, last)

  // flood results stay floods and walk the ports upward
  assign flood_cont = out_valid && flooded && !last;
  `MLSF_ASSERT_NEXT(a_flood_ascending, flood_cont, flooded && (out_port > $past(out_port)))

endmodule

bind mac_learning_switch_forwarder_core mlsf_checker u_mlsf_checker (.*);

`default_nettype wire
